@@ rtl/ostt_pkg.sv @@
// Package for the one-shot timer table: sizes, command and status codes, states.
// No dependencies.
package ostt_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int ENTRY_W = 32 + 8 + 32 + 32;
	localparam logic [31:0] WAIT_CAP = 32'd60000;
	localparam logic [31:0] ALL_ONES = 32'hffffffff;

	localparam logic [2:0] CMD_ARM = 3'd0;
	localparam logic [2:0] CMD_DISARM = 3'd1;
	localparam logic [2:0] CMD_RESTART = 3'd2;
	localparam logic [2:0] CMD_DISCLI = 3'd3;
	localparam logic [2:0] CMD_QUERY = 3'd4;
	localparam logic [2:0] CMD_TICK = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_IDSCAN,
		S_FIRE,
		S_EMIT,
		S_DONE
	} state_t;

	// Slot entry as held in the memory.
	typedef struct packed {
		logic [31:0] id;
		logic [7:0] client;
		logic [31:0] delay;
		logic [31:0] base;
	} entry_t;

endpackage

@@ rtl/one_shot_timer_table_core.sv @@
// One-shot timer table top level: sequencer, valid bits and slot memory (ostt_pkg, ostt_ram).
// A memory pass reads every slot in turn; a command's beat follows one pass after accept,
// arm adds a pass per candidate id in use, and each of a tick's expiry beats follows a further pass.
// A full-table arm or an unused code answers without a pass; busy holds through the last beat,
// so the next command is taken in the cycle after it. The receiver cannot stall beats.
// Reset clears the time, the last given id and all valid bits; memory contents stay undefined.
module one_shot_timer_table_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] command,
	input logic [7:0] client_tag,
	input logic [31:0] delay_ms,
	input logic [31:0] timer_id,
	output logic strobe,
	output logic [1:0] status,
	output logic [31:0] result_id,
	output logic [7:0] fired_client,
	output logic fired,
	output logic [31:0] remaining_ms,
	output logic [15:0] least_wait_ms,
	output logic last
);
	import ostt_pkg::*;

	state_t state_q, state_d;
	logic [NUM_TIMERS-1:0] valid_q, fire_q, fire_left;
	logic [31:0] now_q, last_id_q;
	logic [2:0] cmd_q;
	logic [7:0] tag_q, best_client_q;
	logic [31:0] delay_q, id_q, cand_q, least_q, rem_q, best_id_q;
	logic [SLOT_W-1:0] raddr_q, raddr_s1, free_q, best_q, free_idx;
	logic iss_q, rd_s1, free_ok_q, hit_ok_q, clash_q, best_ok_q, free_ok;
	entry_t rdata, wdata;
	logic we;
	logic [SLOT_W-1:0] waddr;
	logic [31:0] el, rmn;
	logic expired, rd_valid, scan_end, id_hit, clash_now, fire_any, cur_better, pass_go;

	ostt_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TIMERS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr_q), .rdata(rdata)
	);

	// Elapsed and remaining time of the entry just read.
	assign el = now_q - rdata.base;
	assign expired = el >= rdata.delay;
	assign rmn = rdata.delay - el;
	assign rd_valid = rd_s1 && valid_q[raddr_s1];
	assign scan_end = rd_s1 && (raddr_s1 == SLOT_W'(NUM_TIMERS - 1));
	assign id_hit = rd_valid && (rdata.id == id_q);
	assign clash_now = clash_q || (rd_valid && (rdata.id == cand_q));
	assign fire_any = (|fire_q) || (rd_valid && expired);
	assign cur_better = rd_s1 && fire_q[raddr_s1] && (!best_ok_q || rdata.id < best_id_q);
	assign fire_left = fire_q & ~(NUM_TIMERS'(1) << best_q);

	// Lowest free slot.
	always_comb begin
		free_ok = 1'b0;
		free_idx = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (command)
						CMD_ARM: state_d = free_ok ? S_IDSCAN : S_DONE;
						CMD_DISARM, CMD_RESTART, CMD_DISCLI, CMD_QUERY, CMD_TICK:
							state_d = S_SCAN;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: if (scan_end) state_d = (cmd_q == CMD_TICK && fire_any) ? S_FIRE : S_DONE;
			S_IDSCAN: if (scan_end && !clash_now) state_d = S_DONE;
			S_FIRE: if (scan_end) state_d = S_EMIT;
			S_EMIT: state_d = (fire_left == '0) ? S_IDLE : S_FIRE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// A new pass over the memory starts on entering a walking state or on an id clash.
	assign pass_go = ((state_d == S_SCAN || state_d == S_IDSCAN || state_d == S_FIRE) &&
		state_d != state_q) || (state_q == S_IDSCAN && scan_end && clash_now);

	// Memory write: arm stores a new entry, restart rewrites the base.
	always_comb begin
		we = 1'b0;
		waddr = free_q;
		wdata = '{id: cand_q, client: tag_q, delay: delay_q, base: now_q};
		if (state_q == S_DONE && cmd_q == CMD_ARM && free_ok_q) we = 1'b1;
		if (state_q == S_SCAN && cmd_q == CMD_RESTART && id_hit) begin
			we = 1'b1;
			waddr = raddr_s1;
			wdata = rdata;
			wdata.base = now_q;
		end
	end

	// Output beats.
	always_comb begin
		busy = (state_q != S_IDLE);
		strobe = 1'b0;
		status = ST_OK;
		result_id = '0;
		fired_client = '0;
		fired = 1'b0;
		remaining_ms = '0;
		least_wait_ms = '0;
		last = 1'b0;
		case (state_q)
			S_EMIT: begin
				strobe = 1'b1;
				fired = 1'b1;
				result_id = best_id_q;
				fired_client = best_client_q;
				if (fire_left == '0) begin
					last = 1'b1;
					least_wait_ms = least_q[15:0];
				end
			end
			S_DONE: begin
				strobe = 1'b1;
				last = 1'b1;
				case (cmd_q)
					CMD_ARM: begin
						status = free_ok_q ? ST_OK : ST_FULL;
						result_id = free_ok_q ? cand_q : '0;
					end
					CMD_DISARM, CMD_RESTART: status = hit_ok_q ? ST_OK : ST_NOTFOUND;
					CMD_QUERY: begin
						status = hit_ok_q ? ST_OK : ST_NOTFOUND;
						remaining_ms = hit_ok_q ? rem_q : ALL_ONES;
					end
					CMD_TICK: least_wait_ms = least_q[15:0];
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Sequencer registers, read address walk and table state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			fire_q <= '0;
			now_q <= '0;
			last_id_q <= '0;
			cmd_q <= '0;
			tag_q <= '0;
			delay_q <= '0;
			id_q <= '0;
			cand_q <= '0;
			least_q <= '0;
			rem_q <= '0;
			best_id_q <= '0;
			best_client_q <= '0;
			raddr_q <= '0;
			raddr_s1 <= '0;
			free_q <= '0;
			best_q <= '0;
			iss_q <= 1'b0;
			rd_s1 <= 1'b0;
			free_ok_q <= 1'b0;
			hit_ok_q <= 1'b0;
			clash_q <= 1'b0;
			best_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			raddr_s1 <= raddr_q;
			rd_s1 <= iss_q;
			if (pass_go) begin
				iss_q <= 1'b1;
				raddr_q <= '0;
			end else if (iss_q) begin
				raddr_q <= raddr_q + SLOT_W'(1);
				iss_q <= (raddr_q != SLOT_W'(NUM_TIMERS - 1));
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= command;
						tag_q <= client_tag;
						delay_q <= delay_ms;
						id_q <= timer_id;
						free_ok_q <= free_ok;
						free_q <= free_idx;
						hit_ok_q <= 1'b0;
						best_ok_q <= 1'b0;
						clash_q <= 1'b0;
						least_q <= WAIT_CAP;
						fire_q <= '0;
						cand_q <= (last_id_q == ALL_ONES) ? 32'd1 : last_id_q + 32'd1;
						if (command == CMD_TICK) now_q <= now_q + 32'd1;
					end
				end
				S_SCAN: begin
					if (rd_valid) begin
						case (cmd_q)
							CMD_DISARM: if (id_hit) begin
								valid_q[raddr_s1] <= 1'b0;
								hit_ok_q <= 1'b1;
							end
							CMD_RESTART: if (id_hit) hit_ok_q <= 1'b1;
							CMD_QUERY: if (id_hit) begin
								hit_ok_q <= 1'b1;
								rem_q <= expired ? '0 : rmn;
							end
							CMD_DISCLI: if (rdata.client == tag_q)
								valid_q[raddr_s1] <= 1'b0;
							CMD_TICK: begin
								if (expired) fire_q[raddr_s1] <= 1'b1;
								else if (rmn < least_q) least_q <= rmn;
							end
							default: ;
						endcase
					end
				end
				S_IDSCAN: begin
					if (scan_end) begin
						clash_q <= 1'b0;
						if (clash_now)
							cand_q <= (cand_q == ALL_ONES) ? 32'd1 : cand_q + 32'd1;
					end else if (rd_valid && rdata.id == cand_q) begin
						clash_q <= 1'b1;
					end
				end
				S_FIRE: begin
					if (cur_better) begin
						best_ok_q <= 1'b1;
						best_id_q <= rdata.id;
						best_q <= raddr_s1;
						best_client_q <= rdata.client;
					end
				end
				S_EMIT: begin
					fire_q[best_q] <= 1'b0;
					valid_q[best_q] <= 1'b0;
					best_ok_q <= 1'b0;
				end
				S_DONE: begin
					if (cmd_q == CMD_ARM && free_ok_q) begin
						valid_q[free_q] <= 1'b1;
						last_id_q <= cand_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Protocol checks.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n) strobe |-> busy)
		else $error("result beat outside a command");
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n) last |-> strobe)
		else $error("last without a beat");
	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		fired |-> (strobe && status == ST_OK))
		else $error("fired beat malformed");
	a_least_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{16'd0, least_wait_ms} <= WAIT_CAP)
		else $error("least wait above cap");
	a_emit_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> best_ok_q)
		else $error("fire beat without a winner");

endmodule

@@ rtl/ostt_ram.sv @@
// Generic single-port-write, one-read synchronous RAM with a registered read.
// No dependencies.
module ostt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
